/* design/i2cbm_pkg.sv */
// Shared types and constants for the I2C bus monitor.
package i2cbm_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned ELAPSED_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned COUNT_W = 4;

	localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 16'd14900;
	localparam logic [COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [1:0] LINES_BOTH = 2'b11;
	localparam logic [1:0] LINES_SCL_ONLY = 2'b10;

	typedef struct packed {
		logic scl;
		logic sda;
		logic [TIME_W-1:0] time_us;
	} sample_t;

	typedef struct packed {
		logic is_stop;
		logic [BYTE_W-1:0] data_byte;
		logic first_after_start;
		logic acked;
		logic [ELAPSED_W-1:0] elapsed_us;
	} event_t;

	typedef struct packed {
		logic emit;
		event_t ev;
	} result_t;

endpackage

/* design/i2cbm_sample_stage.sv */
// Input register stage that holds one bus sample until the capture logic takes it.
module i2cbm_sample_stage (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input i2cbm_pkg::sample_t sample_in,
	input logic advance,
	output logic valid_s1,
	output i2cbm_pkg::sample_t sample_s1
);
	import i2cbm_pkg::*;

	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample_in;
		end
	end

endmodule

/* design/i2cbm_capture_core.sv */
// Capture state and per-sample decoding of START, STOP, clock edges and timeout.
module i2cbm_capture_core (
	input logic clk,
	input logic arst_n,
	input logic timeout_we,
	input logic [i2cbm_pkg::ELAPSED_W-1:0] timeout_wdata,
	input logic advance,
	input i2cbm_pkg::sample_t sample_s1,
	output i2cbm_pkg::result_t result
);
	import i2cbm_pkg::*;

	logic [1:0] prev_lines_q;
	logic capturing_q;
	logic [BYTE_W-1:0] shift_byte_q;
	logic [COUNT_W-1:0] bit_count_q;
	logic first_pending_q;
	logic [TIME_W-1:0] start_time_q;
	logic [TIME_W-1:0] last_byte_time_q;
	logic [ELAPSED_W-1:0] timeout_q;

	logic [1:0] lines;
	logic start_seen;
	logic stop_seen;
	logic scl_rise;
	logic [COUNT_W-1:0] count_next;
	logic byte_done;
	logic [TIME_W-1:0] since_start;
	logic [TIME_W-1:0] since_byte;
	logic timed_out;

	assign lines = {sample_s1.scl, sample_s1.sda};
	assign start_seen = !capturing_q && prev_lines_q == LINES_BOTH && lines == LINES_SCL_ONLY;
	assign stop_seen = capturing_q && prev_lines_q == LINES_SCL_ONLY && lines == LINES_BOTH;
	assign scl_rise = capturing_q && !stop_seen && sample_s1.scl && !prev_lines_q[1];
	assign count_next = bit_count_q + 4'd1;
	assign byte_done = scl_rise && count_next > BITS_PER_BYTE;
	assign since_start = sample_s1.time_us - start_time_q;
	assign since_byte = sample_s1.time_us - last_byte_time_q;
	assign timed_out = (|since_start[TIME_W-1:ELAPSED_W]) ||
		(since_start[ELAPSED_W-1:0] >= timeout_q);

	always_comb begin
		result.emit = stop_seen || byte_done;
		result.ev.is_stop = stop_seen;
		result.ev.data_byte = stop_seen ? '0 : shift_byte_q;
		result.ev.first_after_start = !stop_seen && first_pending_q;
		result.ev.acked = !stop_seen && !sample_s1.sda;
		result.ev.elapsed_us = stop_seen ? since_start[ELAPSED_W-1:0] :
			since_byte[ELAPSED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (timeout_we) begin
			timeout_q <= timeout_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lines_q <= LINES_BOTH;
			capturing_q <= 1'b0;
			shift_byte_q <= '0;
			bit_count_q <= '0;
			first_pending_q <= 1'b0;
			start_time_q <= '0;
			last_byte_time_q <= '0;
		end else if (advance) begin
			prev_lines_q <= lines;
			if (start_seen) begin
				capturing_q <= 1'b1;
				shift_byte_q <= '0;
				bit_count_q <= '0;
				first_pending_q <= 1'b1;
				start_time_q <= sample_s1.time_us;
				last_byte_time_q <= sample_s1.time_us;
			end else if (stop_seen) begin
				capturing_q <= 1'b0;
			end else if (capturing_q) begin
				if (byte_done) begin
					shift_byte_q <= '0;
					bit_count_q <= '0;
					first_pending_q <= 1'b0;
					last_byte_time_q <= sample_s1.time_us;
				end else if (scl_rise) begin
					shift_byte_q <= {shift_byte_q[BYTE_W-2:0], sample_s1.sda};
					bit_count_q <= count_next;
				end
				if (timed_out) begin
					capturing_q <= 1'b0;
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= BITS_PER_BYTE)
		else $error("bit counter past the ninth clock");

	a_emit_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		result.emit |-> capturing_q)
		else $error("event outside a capture");

	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stop_seen) |=> !capturing_q)
		else $error("capture still open after a stop");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && start_seen) |=> (capturing_q && bit_count_q == '0 && first_pending_q))
		else $error("start did not open a clean capture");

endmodule

/* design/i2cbm_event_stage.sv */
// Result register that holds one event until the consumer takes it.
module i2cbm_event_stage (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input i2cbm_pkg::result_t result,
	output logic room,
	output logic event_valid,
	input logic event_ready,
	output i2cbm_pkg::event_t event_q
);
	import i2cbm_pkg::*;

	assign room = !event_valid || event_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid <= 1'b0;
		end else if (advance) begin
			event_valid <= result.emit;
		end else if (event_ready) begin
			event_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			event_q <= result.ev;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !event_ready) |-> !advance)
		else $error("pending event overwritten");

endmodule

/* design/i2c_bus_monitor_unit.sv */
// Top level of the passive I2C bus monitor.
//
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid/sample_ready    scl, sda, time_us
// event     out        event_valid/event_ready      is_stop, data_byte, first_after_start,
//                                                   acked, elapsed_us
// timeout   in         timeout_we (no wait)         timeout_wdata
//
// A sample's event is offered from the result register: the capture logic works in one pass from
// the input register into the result register. One sample is accepted per cycle while no pending event stalls.
// Reset clears all capture state and loads the timeout register with 14900.
// A pending event that is not taken stalls the input register, and with it sample_ready.
module i2c_bus_monitor_unit (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input logic scl,
	input logic sda,
	input logic [31:0] time_us,
	output logic event_valid,
	input logic event_ready,
	output logic is_stop,
	output logic [7:0] data_byte,
	output logic first_after_start,
	output logic acked,
	output logic [15:0] elapsed_us,
	input logic timeout_we,
	input logic [15:0] timeout_wdata
);
	import i2cbm_pkg::*;

	sample_t sample_in;
	sample_t sample_s1;
	logic valid_s1;
	logic advance;
	logic room;
	result_t result;
	event_t event_q;

	assign sample_in = '{scl: scl, sda: sda, time_us: time_us};
	assign advance = valid_s1 && room;

	i2cbm_sample_stage u_sample (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_in(sample_in),
		.advance(advance),
		.valid_s1(valid_s1),
		.sample_s1(sample_s1)
	);

	i2cbm_capture_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.timeout_we(timeout_we),
		.timeout_wdata(timeout_wdata),
		.advance(advance),
		.sample_s1(sample_s1),
		.result(result)
	);

	i2cbm_event_stage u_event (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.result(result),
		.room(room),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_q(event_q)
	);

	assign is_stop = event_q.is_stop;
	assign data_byte = event_q.data_byte;
	assign first_after_start = event_q.first_after_start;
	assign acked = event_q.acked;
	assign elapsed_us = event_q.elapsed_us;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the passive I2C bus monitor unit.
`timescale 1ns / 100ps

module testbench;
	import i2cbm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic scl = 1'b1;
	logic sda = 1'b1;
	logic [31:0] time_us = '0;
	logic event_valid;
	logic event_ready = 1'b0;
	logic is_stop;
	logic [7:0] data_byte;
	logic first_after_start;
	logic acked;
	logic [15:0] elapsed_us;
	logic timeout_we = 1'b0;
	logic [15:0] timeout_wdata = '0;

	sample_t sample_q[$];
	event_t events_due[$];
	sample_t next_s;
	event_t want_ev;

	logic [1:0] bus_prev;
	bit cap_active;
	logic [7:0] shift_reg;
	logic [3:0] bit_cnt;
	bit first_due;
	logic [31:0] t_start;
	logic [31:0] t_last;
	logic [15:0] timeout_cur;

	logic [31:0] bus_now = '0;
	bit quiet_sender = 1'b0;
	bit quiet_receiver = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done;
	int hold_left;

	int n_errors = 0;
	int n_pushed = 0;
	int n_predicted = 0;
	int n_stop_seen = 0;
	int n_byte_seen = 0;
	int n_settings = 1;

	i2c_bus_monitor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.scl(scl),
		.sda(sda),
		.time_us(time_us),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.is_stop(is_stop),
		.data_byte(data_byte),
		.first_after_start(first_after_start),
		.acked(acked),
		.elapsed_us(elapsed_us),
		.timeout_we(timeout_we),
		.timeout_wdata(timeout_wdata)
	);

	always #1 clk = ~clk;

	task automatic reset_predictor;
		bus_prev = LINES_BOTH;
		cap_active = 1'b0;
		shift_reg = '0;
		bit_cnt = '0;
		first_due = 1'b0;
		t_start = '0;
		t_last = '0;
		timeout_cur = TIMEOUT_RESET;
	endtask

	task automatic predict_sample(input sample_t s);
		logic [1:0] lines;
		logic [31:0] since_start;
		event_t ev;
		bit emit;
		lines = {s.scl, s.sda};
		since_start = s.time_us - t_start;
		ev = '0;
		emit = 1'b0;
		if (!cap_active) begin
			if (bus_prev == LINES_BOTH && lines == LINES_SCL_ONLY) begin
				cap_active = 1'b1;
				shift_reg = '0;
				bit_cnt = '0;
				first_due = 1'b1;
				t_start = s.time_us;
				t_last = s.time_us;
			end
		end else if (bus_prev == LINES_SCL_ONLY && lines == LINES_BOTH) begin
			ev.is_stop = 1'b1;
			ev.elapsed_us = since_start[15:0];
			emit = 1'b1;
			cap_active = 1'b0;
		end else begin
			if (s.scl && !bus_prev[1]) begin
				if (bit_cnt < BITS_PER_BYTE) begin
					shift_reg = {shift_reg[6:0], s.sda};
					bit_cnt = bit_cnt + 4'd1;
				end else begin
					ev.data_byte = shift_reg;
					ev.first_after_start = first_due;
					ev.acked = !s.sda;
					ev.elapsed_us = 16'(s.time_us - t_last);
					emit = 1'b1;
					shift_reg = '0;
					bit_cnt = '0;
					first_due = 1'b0;
					t_last = s.time_us;
				end
			end
			if (since_start >= {16'd0, timeout_cur})
				cap_active = 1'b0;
		end
		bus_prev = lines;
		if (emit) begin
			events_due.push_back(ev);
			n_predicted++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			scl <= 1'b1;
			sda <= 1'b1;
			time_us <= '0;
			reset_predictor();
		end else begin
			if (sample_valid && sample_ready)
				predict_sample(sample_t'({scl, sda, time_us}));
			if (!sample_valid || sample_ready) begin
				if (sample_q.size() > 0 && (quiet_sender || $urandom_range(99) >= 21)) begin
					next_s = sample_q.pop_front();
					sample_valid <= 1'b1;
					scl <= next_s.scl;
					sda <= next_s.sda;
					time_us <= next_s.time_us;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (event_valid && event_ready) begin
				if (is_stop)
					n_stop_seen++;
				else
					n_byte_seen++;
				if (events_due.size() == 0) begin
					n_errors++;
					$display("%0t ns: expected no event, actual stop=%0b byte=%0d first=%0b ack=%0b elapsed=%0d",
						$time, is_stop, data_byte, first_after_start, acked, elapsed_us);
				end else begin
					want_ev = events_due.pop_front();
					check_field("is_stop", 16'(want_ev.is_stop), 16'(is_stop));
					check_field("data_byte", 16'(want_ev.data_byte), 16'(data_byte));
					check_field("first_after_start", 16'(want_ev.first_after_start),
						16'(first_after_start));
					check_field("acked", 16'(want_ev.acked), 16'(acked));
					check_field("elapsed_us", want_ev.elapsed_us, elapsed_us);
				end
			end
			if (hold_left > 0) begin
				event_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_request && !hold_done) begin
				event_ready <= 1'b0;
				hold_left <= 250;
				hold_done <= 1'b1;
			end else begin
				event_ready <= quiet_receiver || $urandom_range(99) >= 21;
			end
		end
	end

	task automatic put_lines(input bit c, input bit d);
		sample_t s;
		if ($urandom_range(399) == 0)
			bus_now += $urandom();
		else if ($urandom_range(199) == 0)
			bus_now += $urandom_range(70000, 20000);
		else
			bus_now += $urandom_range(3);
		s.scl = c;
		s.sda = d;
		s.time_us = bus_now;
		sample_q.push_back(s);
		n_pushed++;
	endtask

	task automatic send_random;
		int unsigned pick;
		int unsigned n_bytes;
		int unsigned cut;
		int unsigned pos;
		int k;
		logic [7:0] cur_byte;
		bit b;
		while (sample_q.size() > 40)
			@(negedge clk);
		pick = $urandom_range(99);
		if (pick < 85) begin
			repeat ($urandom_range(3, 1)) put_lines(1'b1, 1'b1);
			put_lines(1'b1, 1'b0);
			n_bytes = $urandom_range(4, 1);
			cut = (pick >= 72) ? $urandom_range(n_bytes * 9 - 1) : n_bytes * 9;
			cur_byte = '0;
			for (k = 0; k < cut; k++) begin
				pos = k % 9;
				if (pos == 0) begin
					case ($urandom_range(9))
						0: cur_byte = 8'h00;
						1: cur_byte = 8'hFF;
						default: cur_byte = 8'($urandom());
					endcase
				end
				if (pos == 8)
					b = ($urandom_range(3) == 0);
				else
					b = cur_byte[7 - pos];
				put_lines(1'b0, b);
				if ($urandom_range(7) == 0)
					put_lines(1'b0, b);
				put_lines(1'b1, b);
				if (b && $urandom_range(15) == 0)
					put_lines(1'b1, 1'b0);
			end
			if ($urandom_range(9) != 0) begin
				put_lines(1'b0, 1'b0);
				put_lines(1'b1, 1'b0);
				put_lines(1'b1, 1'b1);
			end
		end else begin
			repeat ($urandom_range(12, 3)) put_lines(1'($urandom()), 1'($urandom()));
		end
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (sample_q.size() != 0 || sample_valid || events_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		@(posedge clk);
		timeout_we <= 1'b1;
		timeout_wdata <= value;
		timeout_cur = value;
		@(posedge clk);
		timeout_we <= 1'b0;
		n_settings++;
		@(negedge clk);
	endtask

	initial begin
		int ph;
		int phase_base;
		int unsigned budget [6];
		budget = '{30, 30, 60, 20, 60, 40};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				1: write_timeout(16'd0);
				2: begin
					write_timeout(16'hFFFF);
					hold_request = 1'b1;
				end
				3: write_timeout(16'd1);
				4: begin
					write_timeout(16'($urandom_range(200, 20)));
					quiet_sender = 1'b1;
					quiet_receiver = 1'b1;
				end
				5: begin
					write_timeout(TIMEOUT_RESET);
					quiet_sender = 1'b0;
					quiet_receiver = 1'b0;
				end
				default: ;
			endcase
			if (ph == 0) begin
				// Byte 0x81 across the timestamp wrap, with a repeated START inside it and a
				// long gap before the acknowledge clock edge, then START followed at once by STOP.
				bus_now = 32'hFFFF_FFF0;
				put_lines(1'b1, 1'b1);
				put_lines(1'b1, 1'b0);
				put_lines(1'b0, 1'b1);
				put_lines(1'b1, 1'b1);
				put_lines(1'b1, 1'b0);
				repeat (6) begin
					put_lines(1'b0, 1'b0);
					put_lines(1'b1, 1'b0);
				end
				put_lines(1'b0, 1'b1);
				put_lines(1'b1, 1'b1);
				put_lines(1'b0, 1'b0);
				bus_now += 70000;
				put_lines(1'b1, 1'b0);
				put_lines(1'b1, 1'b1);
				put_lines(1'b1, 1'b0);
				put_lines(1'b1, 1'b1);
			end else begin
				bus_now = (ph == 3) ? 32'hFFFF_F000 : $urandom();
			end
			phase_base = n_pushed;
			while (n_pushed - phase_base < budget[ph]
					|| (ph == 5 && (n_pushed < 450 || n_predicted < 48)))
				send_random();
			wait_drained();
		end
		repeat (8) @(posedge clk);
		$display("Run covered %0d bus samples and %0d events (%0d bytes, %0d stops)",
			n_pushed, n_byte_seen + n_stop_seen, n_byte_seen, n_stop_seen);
		$display("over %0d timeout settings, including zero and the maximum.", n_settings);
		if (n_errors == 0)
			$display("** i2c_bus_monitor_unit: PASSED **");
		else
			$display("** i2c_bus_monitor_unit: FAILED **");
		$finish;
	end

	initial begin
		#800000;
		$display("%0t ns: run did not finish in time", $time);
		$display("** i2c_bus_monitor_unit: FAILED **");
		$finish;
	end

endmodule

/* i2c_bus_monitor_unit.f */
design/i2cbm_pkg.sv
design/i2cbm_sample_stage.sv
design/i2cbm_capture_core.sv
design/i2cbm_event_stage.sv
design/i2c_bus_monitor_unit.sv
dv/testbench.sv
